// ----- rtl/keyword_lexer_token_scanner_core_macros.svh -----
// assertion macros shared by the scanner modules
`ifndef KEYWORD_LEXER_TOKEN_SCANNER_CORE_MACROS_SVH
`define KEYWORD_LEXER_TOKEN_SCANNER_CORE_MACROS_SVH

// same-cycle implication
`define KLTS_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("scanner check failed");

// next-cycle implication
`define KLTS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("scanner check failed");

`endif

// ----- rtl/klts_pkg.sv -----
package klts_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_ZERO   = 3'd3,
      MODE_SLASH  = 3'd4,
      MODE_BRACE  = 3'd5,
      MODE_LINE   = 3'd6
   } scan_mode_type;

   typedef enum logic [4:0] {
      KIND_ID      = 5'd0,
      KIND_NUM     = 5'd1,
      KIND_PROGRAM = 5'd2,
      KIND_CONST   = 5'd3,
      KIND_BEGIN   = 5'd4,
      KIND_END     = 5'd5,
      KIND_DIV     = 5'd6,
      KIND_MOD     = 5'd7,
      KIND_PRINT   = 5'd8,
      KIND_SEMI    = 5'd9,
      KIND_PERIOD  = 5'd10,
      KIND_PLUS    = 5'd11,
      KIND_MINUS   = 5'd12,
      KIND_STAR    = 5'd13,
      KIND_EQUAL   = 5'd14,
      KIND_EOF     = 5'd15,
      KIND_ERROR   = 5'd16
   } token_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_ZERO    = 3'd1,
      ERR_SLASH   = 3'd2,
      ERR_BRACE   = 3'd3,
      ERR_UNKNOWN = 3'd4
   } error_kind_type;

   typedef struct packed {
      token_kind_type kind;
      error_kind_type err;
      logic [7:0]     bad;
      logic           last;
   } token_tag_type;

   localparam int TAG_BITS    = $bits(token_tag_type);
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_STAR    = 8'd42;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_PERIOD  = 8'd46;
   localparam logic [7:0] CHAR_SLASH   = 8'd47;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_ONE     = 8'd49;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_SEMI    = 8'd59;
   localparam logic [7:0] CHAR_EQUAL   = 8'd61;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CHAR_LBRACE  = 8'd123;
   localparam logic [7:0] CHAR_RBRACE  = 8'd125;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   // lower-case keyword text, first byte highest, right aligned
   localparam logic [63:0] KW_PROGRAM = 64'h0070_726f_6772_616d;
   localparam logic [63:0] KW_CONST   = 64'h0000_0063_6f6e_7374;
   localparam logic [63:0] KW_BEGIN   = 64'h0000_0062_6567_696e;
   localparam logic [63:0] KW_END     = 64'h0000_0000_0065_6e64;
   localparam logic [63:0] KW_DIV     = 64'h0000_0000_0064_6976;
   localparam logic [63:0] KW_MOD     = 64'h0000_0000_006d_6f64;
   localparam logic [63:0] KW_PRINT   = 64'h0000_0070_7269_6e74;
   localparam logic [63:0] KW_EOF     = 64'h0000_0000_0065_6f66;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return is_upper(c) || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return is_upper(c) ? c + CASE_OFFSET : c;
   endfunction

   function automatic token_kind_type keyword_kind(input logic [63:0] text);
      token_kind_type kind;
      case (text)
         KW_PROGRAM: kind = KIND_PROGRAM;
         KW_CONST:   kind = KIND_CONST;
         KW_BEGIN:   kind = KIND_BEGIN;
         KW_END:     kind = KIND_END;
         KW_DIV:     kind = KIND_DIV;
         KW_MOD:     kind = KIND_MOD;
         KW_PRINT:   kind = KIND_PRINT;
         KW_EOF:     kind = KIND_EOF;
         default:    kind = KIND_ID;
      endcase
      return kind;
   endfunction

endpackage

// ----- rtl/klts_scan.sv -----
`include "keyword_lexer_token_scanner_core_macros.svh"

module klts_scan #(
   parameter int LINE_BITS     = 16,
   parameter int COLUMN_BITS   = 12,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [7:0]                char_code,
   input  logic                      end_of_input,
   output logic [1:0]                tok_count,
   output klts_pkg::token_tag_type   tag0,
   output logic [LINE_BITS-1:0]      line0,
   output logic [COLUMN_BITS-1:0]    col0,
   output logic [COLUMN_BITS-1:0]    len0,
   output klts_pkg::token_tag_type   tag1,
   output logic [LINE_BITS-1:0]      line1,
   output logic [COLUMN_BITS-1:0]    col1,
   output logic [COLUMN_BITS-1:0]    len1
);

   localparam int BUF_BITS = 8 * KEYWORD_CHARS;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] KW_LEN   = COLUMN_BITS'(KEYWORD_CHARS);
   localparam logic [COLUMN_BITS-1:0] ONE_LEN  = COLUMN_BITS'(1);
   localparam klts_pkg::token_tag_type BLANK_TAG = '{
      kind: klts_pkg::KIND_ID, err: klts_pkg::ERR_NONE, bad: 8'd0, last: 1'b0};

   klts_pkg::scan_mode_type   mode_ff, mode_in;
   logic [LINE_BITS-1:0]      line_ff, line_in;
   logic [COLUMN_BITS-1:0]    col_ff, col_in;
   logic [LINE_BITS-1:0]      sline_ff, sline_in;
   logic [COLUMN_BITS-1:0]    scol_ff, scol_in;
   logic [COLUMN_BITS-1:0]    len_ff, len_in;
   logic [BUF_BITS-1:0]       buf_ff, buf_in;

   logic                      alnum;
   logic [7:0]                lc;
   logic [COLUMN_BITS-1:0]    len_sat;
   klts_pkg::token_kind_type  ident_kind;

   logic                      flush_valid;
   klts_pkg::token_tag_type   flush_tag;
   logic [COLUMN_BITS-1:0]    flush_len;

   logic                      pend_valid;
   klts_pkg::token_tag_type   pend_tag;
   logic [COLUMN_BITS-1:0]    pend_len;
   logic                      new_valid;
   klts_pkg::token_tag_type   new_tag;
   logic                      fresh;

   assign alnum   = klts_pkg::is_letter(char_code) || klts_pkg::is_digit(char_code);
   assign lc      = klts_pkg::to_lower(char_code);
   assign len_sat = (len_ff == COL_MAX) ? len_ff : len_ff + ONE_LEN;
   assign ident_kind = (len_ff > KW_LEN) ? klts_pkg::KIND_ID
                                         : klts_pkg::keyword_kind(64'(buf_ff));

   // token left pending by the current mode
   always_comb begin
      flush_valid = 1'b0;
      flush_tag   = BLANK_TAG;
      flush_len   = '0;
      case (mode_ff)
         klts_pkg::MODE_IDENT: begin
            flush_valid    = 1'b1;
            flush_tag.kind = ident_kind;
            flush_len      = (ident_kind == klts_pkg::KIND_ID) ? len_ff : '0;
         end
         klts_pkg::MODE_NUMBER: begin
            flush_valid    = 1'b1;
            flush_tag.kind = klts_pkg::KIND_NUM;
            flush_len      = len_ff;
         end
         klts_pkg::MODE_ZERO: begin
            flush_valid    = 1'b1;
            flush_tag.kind = klts_pkg::KIND_NUM;
            flush_len      = ONE_LEN;
         end
         klts_pkg::MODE_SLASH: begin
            flush_valid    = 1'b1;
            flush_tag.kind = klts_pkg::KIND_ERROR;
            flush_tag.err  = klts_pkg::ERR_SLASH;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      sline_in   = sline_ff;
      scol_in    = scol_ff;
      len_in     = len_ff;
      buf_in     = buf_ff;
      pend_valid = 1'b0;
      pend_tag   = flush_tag;
      pend_len   = flush_len;
      new_valid  = 1'b0;
      new_tag    = BLANK_TAG;
      fresh      = 1'b0;
      if (end_of_input) begin
         pend_valid   = flush_valid;
         mode_in      = klts_pkg::MODE_IDLE;
         new_valid    = 1'b1;
         new_tag.kind = klts_pkg::KIND_EOF;
      end else begin
         if (char_code == klts_pkg::CHAR_NEWLINE) begin
            line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_BITS'(1);
            col_in  = ONE_LEN;
         end else begin
            col_in  = (col_ff == COL_MAX) ? col_ff : col_ff + ONE_LEN;
         end
         case (mode_ff)
            klts_pkg::MODE_IDENT: begin
               if (alnum) begin
                  if (len_ff < KW_LEN) begin
                     buf_in = {buf_ff[BUF_BITS-9:0], lc};
                  end
                  len_in = len_sat;
               end else begin
                  pend_valid = 1'b1;
                  fresh      = 1'b1;
               end
            end
            klts_pkg::MODE_NUMBER: begin
               if (klts_pkg::is_digit(char_code)) begin
                  len_in = len_sat;
               end else begin
                  pend_valid = 1'b1;
                  fresh      = 1'b1;
               end
            end
            klts_pkg::MODE_ZERO: begin
               pend_valid = 1'b1;
               fresh      = 1'b1;
               if (klts_pkg::is_digit(char_code)) begin
                  pend_tag.kind = klts_pkg::KIND_ERROR;
                  pend_tag.err  = klts_pkg::ERR_ZERO;
                  pend_len      = '0;
               end
            end
            klts_pkg::MODE_SLASH: begin
               if (char_code == klts_pkg::CHAR_SLASH) begin
                  mode_in = klts_pkg::MODE_LINE;
               end else begin
                  pend_valid = 1'b1;
                  fresh      = 1'b1;
               end
            end
            klts_pkg::MODE_BRACE: begin
               if (char_code == klts_pkg::CHAR_RBRACE) begin
                  mode_in = klts_pkg::MODE_IDLE;
               end
            end
            klts_pkg::MODE_LINE: begin
               if (char_code == klts_pkg::CHAR_NEWLINE) begin
                  mode_in = klts_pkg::MODE_IDLE;
               end
            end
            default: begin
               fresh = 1'b1;
            end
         endcase
         // byte starts a new token
         if (fresh) begin
            mode_in  = klts_pkg::MODE_IDLE;
            sline_in = line_ff;
            scol_in  = col_ff;
            if (klts_pkg::is_letter(char_code)) begin
               mode_in = klts_pkg::MODE_IDENT;
               len_in  = ONE_LEN;
               buf_in  = {{(BUF_BITS-8){1'b0}}, lc};
            end else if ((char_code >= klts_pkg::CHAR_ONE) &&
                         (char_code <= klts_pkg::CHAR_NINE)) begin
               mode_in = klts_pkg::MODE_NUMBER;
               len_in  = ONE_LEN;
            end else if (char_code == klts_pkg::CHAR_ZERO) begin
               mode_in = klts_pkg::MODE_ZERO;
            end else if (char_code == klts_pkg::CHAR_SEMI) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_SEMI;
            end else if (char_code == klts_pkg::CHAR_PERIOD) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_PERIOD;
            end else if (char_code == klts_pkg::CHAR_PLUS) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_PLUS;
            end else if (char_code == klts_pkg::CHAR_MINUS) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_MINUS;
            end else if (char_code == klts_pkg::CHAR_STAR) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_STAR;
            end else if (char_code == klts_pkg::CHAR_EQUAL) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_EQUAL;
            end else if (char_code == klts_pkg::CHAR_LBRACE) begin
               mode_in = klts_pkg::MODE_BRACE;
            end else if (char_code == klts_pkg::CHAR_SLASH) begin
               mode_in = klts_pkg::MODE_SLASH;
            end else if (klts_pkg::is_space(char_code)) begin
               mode_in = klts_pkg::MODE_IDLE;
            end else if (char_code == klts_pkg::CHAR_RBRACE) begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_ERROR;
               new_tag.err  = klts_pkg::ERR_BRACE;
            end else begin
               new_valid    = 1'b1;
               new_tag.kind = klts_pkg::KIND_ERROR;
               new_tag.err  = klts_pkg::ERR_UNKNOWN;
               new_tag.bad  = char_code;
            end
         end
      end
   end

   // pending token goes first, then the one this byte makes
   always_comb begin
      tok_count = take ? {pend_valid & new_valid, pend_valid ^ new_valid} : 2'd0;
      tag0      = pend_valid ? pend_tag : new_tag;
      tag0.last = !(pend_valid && new_valid);
      line0     = pend_valid ? sline_ff : line_ff;
      col0      = pend_valid ? scol_ff : col_ff;
      len0      = pend_valid ? pend_len : '0;
      tag1      = new_tag;
      tag1.last = 1'b1;
      line1     = line_ff;
      col1      = col_ff;
      len1      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= klts_pkg::MODE_IDLE;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= ONE_LEN;
         sline_ff <= LINE_BITS'(1);
         scol_ff  <= ONE_LEN;
         len_ff   <= '0;
         buf_ff   <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         len_ff   <= len_in;
         buf_ff   <= buf_in;
      end
   end

   `KLTS_ASSERT_NOW(a_eof_emits, take && end_of_input, tok_count != 2'd0)
   `KLTS_ASSERT_NEXT(a_eof_idles, take && end_of_input, mode_ff == klts_pkg::MODE_IDLE)
   `KLTS_ASSERT_NOW(a_ident_len, mode_ff == klts_pkg::MODE_IDENT, len_ff != '0)
   `KLTS_ASSERT_NOW(a_line_nonzero, 1'b1, (line_ff != '0) && (col_ff != '0))

endmodule

// ----- rtl/klts_queue.sv -----
`include "keyword_lexer_token_scanner_core_macros.svh"

module klts_queue #(
   parameter int DATA_BITS = 57
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  logic [DATA_BITS-1:0] push_data0,
   input  logic [DATA_BITS-1:0] push_data1,
   input  logic                 pop,
   output logic                 out_valid,
   output logic [DATA_BITS-1:0] out_data,
   output logic                 room_two
);

   localparam int PTR_BITS = $clog2(klts_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   logic [DATA_BITS-1:0] entry_ff [klts_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= CNT_BITS'(klts_pkg::QUEUE_DEPTH - 2));
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(do_pop);
      count_in  = count_ff + CNT_BITS'(push_count) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `KLTS_ASSERT_NOW(a_push_room, push_count != 2'd0, room_two)
   `KLTS_ASSERT_NOW(a_push_code, 1'b1, push_count != 2'd3)
   `KLTS_ASSERT_NEXT(a_hold, out_valid && !pop && (push_count == 2'd0), count_ff == $past(count_ff))

endmodule

// ----- rtl/keyword_lexer_token_scanner_core.sv -----
// a token is written into the token queue on the transfer of the byte that ends it, and rsp
// offers it from the queue; throughput: one input transfer per cycle while the four-entry
// token queue has two free entries; one token leaves per cycle while rsp_ready is high
// reset: synchronous, active high; scanner idle, line and column at 1, token queue empty
module keyword_lexer_token_scanner_core #(
   parameter int LINE_BITS     = 16,
   parameter int COLUMN_BITS   = 12,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_code,
   input  logic                   req_end_of_input,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_token_kind,
   output logic [2:0]             rsp_error_kind,
   output logic [LINE_BITS-1:0]   rsp_token_line,
   output logic [COLUMN_BITS-1:0] rsp_token_column,
   output logic [COLUMN_BITS-1:0] rsp_token_length,
   output logic [7:0]             rsp_bad_char,
   output logic                   rsp_last_of_run
);

   localparam int DATA_BITS = klts_pkg::TAG_BITS + LINE_BITS + 2 * COLUMN_BITS;

   logic                    take;
   logic [1:0]              tok_count;
   klts_pkg::token_tag_type tag0, tag1, out_tag;
   logic [LINE_BITS-1:0]    line0, line1;
   logic [COLUMN_BITS-1:0]  col0, col1, len0, len1;
   logic [DATA_BITS-1:0]    out_data;

   assign take = req_valid && req_ready;

   klts_scan #(
      .LINE_BITS     (LINE_BITS),
      .COLUMN_BITS   (COLUMN_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .tok_count    (tok_count),
      .tag0         (tag0),
      .line0        (line0),
      .col0         (col0),
      .len0         (len0),
      .tag1         (tag1),
      .line1        (line1),
      .col1         (col1),
      .len1         (len1)
   );

   klts_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (tok_count),
      .push_data0 ({tag0, line0, col0, len0}),
      .push_data1 ({tag1, line1, col1, len1}),
      .pop        (rsp_ready),
      .out_valid  (rsp_valid),
      .out_data   (out_data),
      .room_two   (req_ready)
   );

   assign out_tag          = out_data[DATA_BITS-1 -: klts_pkg::TAG_BITS];
   assign rsp_token_kind   = out_tag.kind;
   assign rsp_error_kind   = out_tag.err;
   assign rsp_bad_char     = out_tag.bad;
   assign rsp_last_of_run  = out_tag.last;
   assign rsp_token_line   = out_data[2*COLUMN_BITS +: LINE_BITS];
   assign rsp_token_column = out_data[COLUMN_BITS +: COLUMN_BITS];
   assign rsp_token_length = out_data[COLUMN_BITS-1:0];

endmodule
